// ----- design/iirfr_pkg.sv -----
// Shared constants, types and arithmetic helpers for the IIR frequency response bin block.
package iirfr_pkg;

    // Filter shape
    localparam int TAPS       = 5;
    localparam int MAX_HALF   = 32768;
    localparam int ANGLE_BITS = 16;

    // Register map
    localparam int CFG_IDX_W  = $clog2(TAPS + 2);
    localparam int REG_SHIFT  = TAPS;
    localparam int REG_HALF   = TAPS + 1;
    localparam logic [63:0] TAP0_RESET = 64'd134217728;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Angle divider
    localparam int KW    = 16;
    localparam int HW    = 16;
    localparam int JW    = $clog2(TAPS);
    localparam int QB    = JW + ANGLE_BITS - 1;
    localparam int NW    = KW + QB + 1;
    localparam int RW    = HW + 1;
    localparam int LANES = 2 * TAPS;

    // Sums and normalization
    localparam int PROD_W = 48;
    localparam int SUM_W  = PROD_W + JW;
    localparam int SH_W   = $clog2(SUM_W);
    localparam int E_W    = 8;
    localparam int E_BIAS = 26;

    // Quotient
    localparam int MAG_W = 62;
    localparam int H_W   = MAG_W + 16;
    localparam int RQ_W  = MAG_W + 1;
    localparam int QSTEPS = 32;

    // Stage positions (index into the valid / status chain)
    localparam int ST_FOLD = QB + 12;
    localparam int ST_OVF  = QB + 18;
    localparam int LAT     = QB + 51;

    // Quarter-wave sine coefficients, Horner order (highest first)
    localparam logic signed [32:0] K_POLY [7] = '{
        33'sd61, 33'sd3864, 33'sd172272, 33'sd5026993,
        33'sd85569306, 33'sd693598670, 33'sd1686629713
    };

    typedef struct packed {
        logic        neg;
        logic [30:0] x;
    } t_arg;

    // Turn angle to quadrant sign and Q30 position within the quarter
    function automatic t_arg arg_of(input logic [ANGLE_BITS-1:0] t);
        logic [1:0]            q;
        logic [ANGLE_BITS-2:0] r;
        t_arg                  a;
        q = t[ANGLE_BITS-1:ANGLE_BITS-2];
        r = {1'b0, t[ANGLE_BITS-3:0]};
        if (q[0]) begin
            r = (ANGLE_BITS-1)'(1 << (ANGLE_BITS - 2)) - r;
        end
        a.neg = q[1];
        a.x   = 31'(r) << (32 - ANGLE_BITS);
        return a;
    endfunction

    function automatic logic [30:0] sq30(input logic [30:0] x);
        logic [61:0] m;
        m = x * x;
        return m[60:30];
    endfunction

    function automatic logic signed [32:0] poly_step(input logic signed [32:0] k,
                                                     input logic signed [32:0] p,
                                                     input logic [30:0] x2);
        logic signed [64:0] m;
        m = p * $signed({1'b0, x2});
        return 33'(k - (m >>> 30));
    endfunction

    function automatic logic signed [31:0] sin_out(input logic signed [32:0] p,
                                                   input logic [30:0] x,
                                                   input logic neg);
        logic signed [64:0] m;
        logic signed [31:0] v;
        m = p * $signed({1'b0, x});
        v = 32'(m >>> 30);
        return neg ? -v : v;
    endfunction

    function automatic logic signed [PROD_W-1:0] tap_term(input logic signed [31:0] a,
                                                          input logic signed [31:0] b);
        logic signed [63:0] m;
        m = a * b;
        return m[63:16];
    endfunction

    // Magnitude bits of a two's complement value
    function automatic logic [SUM_W-1:0] fold(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? ~v : v;
    endfunction

    // Least right shift that brings the folded value below 2^30
    function automatic logic [SH_W-1:0] shamt(input logic [SUM_W-1:0] m);
        logic [SH_W-1:0] s;
        s = '0;
        for (int i = 30; i < SUM_W; i++) begin
            if (m[i]) begin
                s = SH_W'(i - 29);
            end
        end
        return s;
    endfunction

    // Dividend bits above weight 2^32, i.e. floor(mag * 2^(e-32))
    function automatic logic [H_W-1:0] hi_part(input logic [MAG_W-1:0] mag,
                                               input logic signed [E_W-1:0] e);
        logic [H_W-1:0] w;
        logic [E_W-1:0] a;
        w = H_W'(mag);
        if (e >= E_W'(32)) begin
            a = E_W'(e - E_W'(32));
            return w << a;
        end
        a = E_W'(E_W'(32) - e);
        return w >> a;
    endfunction

    // Dividend bits of weight 2^31 .. 2^0
    function automatic logic [31:0] lo_part(input logic [MAG_W-1:0] mag,
                                            input logic signed [E_W-1:0] e);
        logic [E_W-1:0] a;
        if (e >= 0) begin
            a = e;
            return 32'(mag << a);
        end
        a = E_W'(-e);
        return 32'(mag >> a);
    endfunction

    function automatic logic [31:0] sat_out(input logic [31:0] q, input logic ovf,
                                            input logic neg);
        if (neg) begin
            if (ovf || q > 32'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'(33'd0 - {1'b0, q});
        end
        if (ovf || q[31]) begin
            return 32'h7FFF_FFFF;
        end
        return q;
    endfunction

endpackage

// ----- design/iir_frequency_response_bin.sv -----
// Pipelined frequency response of a five-tap IIR filter at one bin.
//
// Usage:
//   Slave stream takes one bin index per word (tdata[15:0]). Master stream returns
//   one word per bin: tdata[31:0] real part, tdata[63:32] imaginary part (Q5.26 at
//   numerator shift 0, saturated), tuser[1:0] status (0 ok, 1 zero denominator, 2 bin beyond half).
//   Configuration port writes tap pairs (index 0..4), numerator shift (5) and
//   half_bins (6); it is always ready. It is to be written only while no word is in flight;
//   the block itself does not enforce this.
// Pipeline: includes the bit-per-stage angle divider (18 stages), the 9-stage sine
//   polynomial and the bit-per-stage quotient divider (32 stages).
// Throughput: one bin per cycle while the master side is not stalled; all stages advance together.
// Stall: while a result waits on the master side the whole pipeline holds, the slave
//   side drops tready, and no word is lost or repeated.
// Reset: clears all valid bits and loads tap 0 with a0 = 1.0, all else zero, half 1.
module iir_frequency_response_bin (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] bin_index
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] real_part, [63:32] imag_part
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [iirfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int QB    = iirfr_pkg::QB;
    localparam int RW    = iirfr_pkg::RW;
    localparam int NW    = iirfr_pkg::NW;
    localparam int HW    = iirfr_pkg::HW;
    localparam int JW    = iirfr_pkg::JW;
    localparam int TAPS  = iirfr_pkg::TAPS;
    localparam int LANES = iirfr_pkg::LANES;
    localparam int AB    = iirfr_pkg::ANGLE_BITS;
    localparam int SUM_W = iirfr_pkg::SUM_W;
    localparam int PROD_W = iirfr_pkg::PROD_W;
    localparam int SH_W  = iirfr_pkg::SH_W;
    localparam int E_W   = iirfr_pkg::E_W;
    localparam int MAG_W = iirfr_pkg::MAG_W;
    localparam int H_W   = iirfr_pkg::H_W;
    localparam int RQ_W  = iirfr_pkg::RQ_W;
    localparam int QS    = iirfr_pkg::QSTEPS;
    localparam int LAT   = iirfr_pkg::LAT;

    // Configuration registers
    logic [63:0]   r_tap [TAPS];
    logic [4:0]    r_nshift;
    logic [HW-1:0] r_half;
    logic [HW-1:0] w_half;

    // Control
    logic             w_adv;
    logic             w_fire;
    logic [LAT-1:0]   r_vld;
    logic [1:0]       r_st [LAT];
    logic             r_out_valid;
    logic [63:0]      r_out_data;
    logic [1:0]       r_out_user;

    // Angle divider
    logic [RW-1:0] r_dr [QB+1][TAPS];
    logic [QB-1:0] r_dn [QB+1][TAPS];
    logic [QB-1:0] r_dq [QB+1][TAPS];

    // Sine / cosine lanes
    logic [30:0]        r_x   [8][LANES];
    logic               r_neg [8][LANES];
    logic [30:0]        r_x2  [1:6][LANES];
    logic signed [32:0] r_p   [1:7][LANES];
    logic signed [31:0] r_cs  [LANES];

    // Tap products and sums
    logic signed [PROD_W-1:0] r_tbx [TAPS];
    logic signed [PROD_W-1:0] r_tby [TAPS];
    logic signed [PROD_W-1:0] r_tax [TAPS];
    logic signed [PROD_W-1:0] r_tay [TAPS];
    logic signed [SUM_W-1:0]  n_bx, n_by, n_ax, n_ay;
    logic signed [SUM_W-1:0]  r_s_bx, r_s_by, r_s_ax, r_s_ay;
    logic signed [SUM_W-1:0]  r_f_bx, r_f_by, r_f_ax, r_f_ay;
    logic [SUM_W-1:0]         r_mb, r_ma;
    logic signed [SUM_W-1:0]  r_h_bx, r_h_by, r_h_ax, r_h_ay;
    logic [SH_W-1:0]          r_sb, r_sa;
    logic signed [SUM_W-1:0]  w_tbx, w_tby, w_tax, w_tay;
    logic signed [30:0]       r_nbx, r_nby, r_nax, r_nay;
    logic signed [E_W-1:0]    r_ne, r_me, r_ce;
    logic signed [61:0]       r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic signed [62:0]       w_nre, w_nim;
    logic [MAG_W-1:0]         r_mag [2];
    logic                     r_mneg [2];
    logic [MAG_W-1:0]         r_cden;

    // Quotient divider
    logic [H_W-1:0]   r_h   [2];
    logic [31:0]      r_hml [2];
    logic             r_hneg [2];
    logic [MAG_W-1:0] r_hden;
    logic [RQ_W-1:0]  r_qr   [QS+1][2];
    logic [31:0]      r_qml  [QS+1][2];
    logic [31:0]      r_qq   [QS+1][2];
    logic             r_qovf [QS+1][2];
    logic             r_qneg [QS+1][2];
    logic [MAG_W-1:0] r_qden [QS+1];

    assign w_half = (r_half == '0) ? HW'(1) :
                    (({1'b0, r_half} > (HW+1)'(iirfr_pkg::MAX_HALF)) ?
                     HW'(iirfr_pkg::MAX_HALF) : r_half);

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = i_s_axis_tvalid && w_adv;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                r_tap[j] <= (j == 0) ? iirfr_pkg::TAP0_RESET : 64'd0;
            end
            r_nshift <= '0;
            r_half   <= HW'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index < iirfr_pkg::CFG_IDX_W'(TAPS)) begin
                r_tap[i_cfg_index[JW-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == iirfr_pkg::CFG_IDX_W'(iirfr_pkg::REG_SHIFT)) begin
                r_nshift <= i_cfg_data[4:0];
            end else if (i_cfg_index == iirfr_pkg::CFG_IDX_W'(iirfr_pkg::REG_HALF)) begin
                r_half <= i_cfg_data[HW-1:0];
            end
        end
    end

    // Valid chain and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[LAT-2:0], w_fire};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // Status travels with the word; zero denominator is flagged at the fold stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= ({1'b0, i_s_axis_tdata} > {1'b0, w_half}) ?
                       iirfr_pkg::ST_RANGE : iirfr_pkg::ST_OK;
            for (int i = 1; i < LAT; i++) begin
                if (i == iirfr_pkg::ST_FOLD && r_s_ax == '0 && r_s_ay == '0 &&
                    r_st[i-1] == iirfr_pkg::ST_OK) begin
                    r_st[i] <= iirfr_pkg::ST_ZERO;
                end else begin
                    r_st[i] <= r_st[i-1];
                end
            end
        end
    end

    // Angle numerator k*j*2^(AB-1) + half/2, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        logic [RW-1:0] rr;
        if (w_adv) begin
            for (int j = 0; j < TAPS; j++) begin
                num = (NW'(i_s_axis_tdata) * NW'(j) << (AB - 1)) + NW'(w_half >> 1);
                r_dr[0][j] <= RW'(num >> QB);
                r_dn[0][j] <= num[QB-1:0];
                r_dq[0][j] <= '0;
            end
            for (int d = 1; d <= QB; d++) begin
                for (int j = 0; j < TAPS; j++) begin
                    rr = {r_dr[d-1][j][RW-2:0], r_dn[d-1][j][QB-d]};
                    if (rr >= {1'b0, w_half}) begin
                        r_dr[d][j] <= rr - {1'b0, w_half};
                        r_dq[d][j] <= {r_dq[d-1][j][QB-2:0], 1'b1};
                    end else begin
                        r_dr[d][j] <= rr;
                        r_dq[d][j] <= {r_dq[d-1][j][QB-2:0], 1'b0};
                    end
                    r_dn[d][j] <= r_dn[d-1][j];
                end
            end
        end
    end

    // Sine / cosine: quadrant fold, x^2, six Horner steps, final product with sign
    always_ff @(posedge i_clk) begin
        logic [AB-1:0]   t;
        iirfr_pkg::t_arg as;
        iirfr_pkg::t_arg ac;
        if (w_adv) begin
            for (int j = 0; j < TAPS; j++) begin
                t  = AB'(0) - r_dq[QB][j][AB-1:0];
                as = iirfr_pkg::arg_of(t);
                ac = iirfr_pkg::arg_of(t + AB'(1 << (AB - 2)));
                r_x[0][2*j]     <= ac.x;
                r_neg[0][2*j]   <= ac.neg;
                r_x[0][2*j+1]   <= as.x;
                r_neg[0][2*j+1] <= as.neg;
            end
            for (int l = 0; l < LANES; l++) begin
                r_x2[1][l] <= iirfr_pkg::sq30(r_x[0][l]);
                r_p[1][l]  <= iirfr_pkg::K_POLY[0];
                for (int g = 1; g < 8; g++) begin
                    r_x[g][l]   <= r_x[g-1][l];
                    r_neg[g][l] <= r_neg[g-1][l];
                end
                for (int g = 2; g < 8; g++) begin
                    r_p[g][l] <= iirfr_pkg::poly_step(iirfr_pkg::K_POLY[g-1],
                                                      r_p[g-1][l], r_x2[g-1][l]);
                end
                for (int g = 2; g < 7; g++) begin
                    r_x2[g][l] <= r_x2[g-1][l];
                end
                r_cs[l] <= iirfr_pkg::sin_out(r_p[7][l], r_x[7][l], r_neg[7][l]);
            end
        end
    end

    // Tap sums
    always_comb begin
        n_bx = '0;
        n_by = '0;
        n_ax = '0;
        n_ay = '0;
        for (int j = 0; j < TAPS; j++) begin
            n_bx = n_bx + SUM_W'(r_tbx[j]);
            n_by = n_by + SUM_W'(r_tby[j]);
            n_ax = n_ax + SUM_W'(r_tax[j]);
            n_ay = n_ay + SUM_W'(r_tay[j]);
        end
    end

    assign w_tbx = r_h_bx >>> r_sb;
    assign w_tby = r_h_by >>> r_sb;
    assign w_tax = r_h_ax >>> r_sa;
    assign w_tay = r_h_ay >>> r_sa;
    assign w_nre = 63'(r_m1) + 63'(r_m2);
    assign w_nim = 63'(r_m3) - 63'(r_m4);

    // Products, sums, block normalization, complex products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < TAPS; j++) begin
                r_tbx[j] <= iirfr_pkg::tap_term(r_tap[j][63:32], r_cs[2*j]);
                r_tby[j] <= iirfr_pkg::tap_term(r_tap[j][63:32], r_cs[2*j+1]);
                r_tax[j] <= iirfr_pkg::tap_term(r_tap[j][31:0], r_cs[2*j]);
                r_tay[j] <= iirfr_pkg::tap_term(r_tap[j][31:0], r_cs[2*j+1]);
            end
            r_s_bx <= n_bx;
            r_s_by <= n_by;
            r_s_ax <= n_ax;
            r_s_ay <= n_ay;
            // fold
            r_mb   <= iirfr_pkg::fold(r_s_bx) | iirfr_pkg::fold(r_s_by);
            r_ma   <= iirfr_pkg::fold(r_s_ax) | iirfr_pkg::fold(r_s_ay);
            r_f_bx <= r_s_bx;
            r_f_by <= r_s_by;
            r_f_ax <= r_s_ax;
            r_f_ay <= r_s_ay;
            // shift amounts
            r_sb   <= iirfr_pkg::shamt(r_mb);
            r_sa   <= iirfr_pkg::shamt(r_ma);
            r_h_bx <= r_f_bx;
            r_h_by <= r_f_by;
            r_h_ax <= r_f_ax;
            r_h_ay <= r_f_ay;
            // normalize and exponent
            r_nbx <= w_tbx[30:0];
            r_nby <= w_tby[30:0];
            r_nax <= w_tax[30:0];
            r_nay <= w_tay[30:0];
            r_ne  <= E_W'($signed({1'b0, r_sb})) - E_W'($signed({1'b0, r_sa}))
                     - E_W'($signed({1'b0, r_nshift})) + E_W'(iirfr_pkg::E_BIAS);
            // complex products
            r_m1 <= r_nbx * r_nax;
            r_m2 <= r_nby * r_nay;
            r_m3 <= r_nby * r_nax;
            r_m4 <= r_nbx * r_nay;
            r_m5 <= r_nax * r_nax;
            r_m6 <= r_nay * r_nay;
            r_me <= r_ne;
            // numerator magnitudes and |A|^2
            r_mag[0]  <= MAG_W'(w_nre[62] ? -w_nre : w_nre);
            r_mneg[0] <= w_nre[62];
            r_mag[1]  <= MAG_W'(w_nim[62] ? -w_nim : w_nim);
            r_mneg[1] <= w_nim[62];
            r_cden    <= MAG_W'(r_m5) + MAG_W'(r_m6);
            r_ce      <= r_me;
            // align dividend around weight 2^32
            for (int l = 0; l < 2; l++) begin
                r_h[l]    <= iirfr_pkg::hi_part(r_mag[l], r_ce);
                r_hml[l]  <= iirfr_pkg::lo_part(r_mag[l], r_ce);
                r_hneg[l] <= r_mneg[l];
            end
            r_hden <= r_cden;
        end
    end

    // Quotient: overflow test, then one bit per stage
    always_ff @(posedge i_clk) begin
        logic [RQ_W-1:0] rr;
        if (w_adv) begin
            for (int l = 0; l < 2; l++) begin
                r_qovf[0][l] <= (r_h[l] >= H_W'(r_hden));
                r_qr[0][l]   <= r_h[l][RQ_W-1:0];
                r_qml[0][l]  <= r_hml[l];
                r_qq[0][l]   <= '0;
                r_qneg[0][l] <= r_hneg[l];
            end
            r_qden[0] <= r_hden;
            for (int d = 1; d <= QS; d++) begin
                for (int l = 0; l < 2; l++) begin
                    rr = {r_qr[d-1][l][RQ_W-2:0], r_qml[d-1][l][QS-d]};
                    if (rr >= {1'b0, r_qden[d-1]}) begin
                        r_qr[d][l] <= rr - {1'b0, r_qden[d-1]};
                        r_qq[d][l] <= {r_qq[d-1][l][30:0], 1'b1};
                    end else begin
                        r_qr[d][l] <= rr;
                        r_qq[d][l] <= {r_qq[d-1][l][30:0], 1'b0};
                    end
                    r_qml[d][l]  <= r_qml[d-1][l];
                    r_qovf[d][l] <= r_qovf[d-1][l];
                    r_qneg[d][l] <= r_qneg[d-1][l];
                end
                r_qden[d] <= r_qden[d-1];
            end
        end
    end

    // Output word: sign, saturation, special cases
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_user <= r_st[LAT-1];
            if (r_st[LAT-1] == iirfr_pkg::ST_OK) begin
                r_out_data <= {iirfr_pkg::sat_out(r_qq[QS][1], r_qovf[QS][1], r_qneg[QS][1]),
                               iirfr_pkg::sat_out(r_qq[QS][0], r_qovf[QS][0], r_qneg[QS][0])};
            end else begin
                r_out_data <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    // Special-case results carry zero data
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user != iirfr_pkg::ST_OK |-> r_out_data == '0)
        else $error("special-case result with nonzero data");

    // Angle divider remainder stays below half for in-range bins
    a_angle_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && r_st[QB] != iirfr_pkg::ST_RANGE |-> r_dr[QB][0] < {1'b0, w_half})
        else $error("angle divider remainder out of range");

    // Nonzero denominator reaches the quotient divider for ok words
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[iirfr_pkg::ST_OVF] && r_st[iirfr_pkg::ST_OVF] == iirfr_pkg::ST_OK
        |-> r_qden[0] != '0)
        else $error("zero denominator in quotient divider");

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result changed");
`endif

endmodule
